### src/bfp_pkg.sv
// Shared types, constants and microcode for the brainfuck processor.
package bfp_pkg;

    localparam int TAPE_DEPTH = 4096;
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int LEN_W      = PROG_AW + 1;

    localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
    localparam logic [LEN_W-1:0]   PROG_FULL = LEN_W'(PROG_DEPTH);

    // Actions
    localparam logic [1:0] A_RESTART = 2'd0;
    localparam logic [1:0] A_LOAD    = 2'd1;
    localparam logic [1:0] A_STEP    = 2'd2;
    localparam logic [1:0] A_ERASE   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_HALT    = 3'd2;
    localparam logic [2:0] ST_PTR     = 3'd3;
    localparam logic [2:0] ST_BRACKET = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    // Program characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef logic [5:0] t_upc;
    typedef logic [4:0] t_act;
    typedef logic [4:0] t_cond;

    // Datapath operations
    localparam t_act ACT_NOP        = 5'd0;
    localparam t_act ACT_LATCH      = 5'd1;
    localparam t_act ACT_CLR_INIT   = 5'd2;
    localparam t_act ACT_CLR_WRITE  = 5'd3;
    localparam t_act ACT_CLR_BOOT   = 5'd4;
    localparam t_act ACT_REPORT     = 5'd5;
    localparam t_act ACT_LOAD_WRITE = 5'd6;
    localparam t_act ACT_STAT_FULL  = 5'd7;
    localparam t_act ACT_ERASE      = 5'd8;
    localparam t_act ACT_COPY_STATE = 5'd9;
    localparam t_act ACT_SET_HALT   = 5'd10;
    localparam t_act ACT_SET_PTR    = 5'd11;
    localparam t_act ACT_SET_BRK    = 5'd12;
    localparam t_act ACT_SET_WAIT   = 5'd13;
    localparam t_act ACT_FINISH     = 5'd14;
    localparam t_act ACT_READ_OP    = 5'd15;
    localparam t_act ACT_INC_CELL   = 5'd16;
    localparam t_act ACT_DEC_CELL   = 5'd17;
    localparam t_act ACT_DP_INC     = 5'd18;
    localparam t_act ACT_DP_DEC     = 5'd19;
    localparam t_act ACT_EMIT       = 5'd20;
    localparam t_act ACT_STORE_IN   = 5'd21;
    localparam t_act ACT_PC_INC     = 5'd22;
    localparam t_act ACT_FWD_INIT   = 5'd23;
    localparam t_act ACT_FWD_READ   = 5'd24;
    localparam t_act ACT_FWD_STEP   = 5'd25;
    localparam t_act ACT_BWD_INIT   = 5'd26;
    localparam t_act ACT_BWD_READ   = 5'd27;
    localparam t_act ACT_BWD_STEP   = 5'd28;

    // Jump conditions
    localparam t_cond C_NEVER     = 5'd0;
    localparam t_cond C_ALWAYS    = 5'd1;
    localparam t_cond C_NO_START  = 5'd2;
    localparam t_cond C_RESTART   = 5'd3;
    localparam t_cond C_LOAD      = 5'd4;
    localparam t_cond C_ERASE     = 5'd5;
    localparam t_cond C_STOPPED   = 5'd6;
    localparam t_cond C_PC_END    = 5'd7;
    localparam t_cond C_DISPATCH  = 5'd8;
    localparam t_cond C_FULL      = 5'd9;
    localparam t_cond C_DP_LAST   = 5'd10;
    localparam t_cond C_DP_ZERO   = 5'd11;
    localparam t_cond C_NO_INPUT  = 5'd12;
    localparam t_cond C_CELL_NZ   = 5'd13;
    localparam t_cond C_CELL_ZERO = 5'd14;
    localparam t_cond C_IDX_END   = 5'd15;
    localparam t_cond C_IDX_ZERO  = 5'd16;
    localparam t_cond C_NO_MFWD   = 5'd17;
    localparam t_cond C_NO_MBWD   = 5'd18;
    localparam t_cond C_CLR_MORE  = 5'd19;
    localparam t_cond C_BOOT      = 5'd20;

    // Microcode addresses
    localparam t_upc U_CLR_INIT = 6'd0;
    localparam t_upc U_CLR_LOOP = 6'd1;
    localparam t_upc U_CLR_DONE = 6'd2;
    localparam t_upc U_REPORT   = 6'd3;
    localparam t_upc U_IDLE     = 6'd4;
    localparam t_upc U_DEC_R    = 6'd5;
    localparam t_upc U_DEC_L    = 6'd6;
    localparam t_upc U_DEC_E    = 6'd7;
    localparam t_upc U_STEP     = 6'd8;
    localparam t_upc U_STEP_END = 6'd9;
    localparam t_upc U_FETCH    = 6'd10;
    localparam t_upc U_DISPATCH = 6'd11;
    localparam t_upc U_LOAD     = 6'd12;
    localparam t_upc U_LOAD_WR  = 6'd13;
    localparam t_upc U_LFULL    = 6'd14;
    localparam t_upc U_ERASE    = 6'd15;
    localparam t_upc U_STOPPED  = 6'd16;
    localparam t_upc U_HALT     = 6'd17;
    localparam t_upc U_PTR      = 6'd18;
    localparam t_upc U_BRK      = 6'd19;
    localparam t_upc U_WAIT     = 6'd20;
    localparam t_upc U_FINISH   = 6'd21;
    localparam t_upc U_PLUS     = 6'd22;
    localparam t_upc U_MINUS    = 6'd23;
    localparam t_upc U_RIGHT    = 6'd24;
    localparam t_upc U_RIGHT_GO = 6'd25;
    localparam t_upc U_LEFT     = 6'd26;
    localparam t_upc U_LEFT_GO  = 6'd27;
    localparam t_upc U_DOT      = 6'd28;
    localparam t_upc U_COMMA    = 6'd29;
    localparam t_upc U_COMMA_GO = 6'd30;
    localparam t_upc U_OPEN     = 6'd31;
    localparam t_upc U_FWD_INIT = 6'd32;
    localparam t_upc U_FWD_RD   = 6'd33;
    localparam t_upc U_FWD_STEP = 6'd34;
    localparam t_upc U_FWD_DONE = 6'd35;
    localparam t_upc U_CLOSE    = 6'd36;
    localparam t_upc U_BWD_INIT = 6'd37;
    localparam t_upc U_BWD_RD   = 6'd38;
    localparam t_upc U_BWD_STEP = 6'd39;
    localparam t_upc U_BWD_DONE = 6'd40;
    localparam t_upc U_SKIP     = 6'd41;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  tgt;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic       is_restart;
        logic       is_load;
        logic       is_erase;
        logic       stopped;
        logic       pc_end;
        logic       full;
        logic       dp_last;
        logic       dp_zero;
        logic       no_input;
        logic       cell_zero;
        logic       idx_end;
        logic       idx_zero;
        logic       match_fwd;
        logic       match_bwd;
        logic       clr_more;
        logic       boot;
        logic [7:0] op;
    } t_flags;

    function automatic t_uword mk(input t_act a, input t_cond c, input t_upc t);
        t_uword w;
        w.act  = a;
        w.cond = c;
        w.tgt  = t;
        return w;
    endfunction

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            U_CLR_INIT: w = mk(ACT_CLR_INIT,   C_NEVER,     U_IDLE);
            U_CLR_LOOP: w = mk(ACT_CLR_WRITE,  C_CLR_MORE,  U_CLR_LOOP);
            U_CLR_DONE: w = mk(ACT_CLR_BOOT,   C_BOOT,      U_IDLE);
            U_REPORT:   w = mk(ACT_REPORT,     C_ALWAYS,    U_IDLE);
            U_IDLE:     w = mk(ACT_LATCH,      C_NO_START,  U_IDLE);
            U_DEC_R:    w = mk(ACT_NOP,        C_RESTART,   U_CLR_INIT);
            U_DEC_L:    w = mk(ACT_NOP,        C_LOAD,      U_LOAD);
            U_DEC_E:    w = mk(ACT_NOP,        C_ERASE,     U_ERASE);
            U_STEP:     w = mk(ACT_NOP,        C_STOPPED,   U_STOPPED);
            U_STEP_END: w = mk(ACT_NOP,        C_PC_END,    U_HALT);
            U_FETCH:    w = mk(ACT_READ_OP,    C_NEVER,     U_IDLE);
            U_DISPATCH: w = mk(ACT_NOP,        C_DISPATCH,  U_SKIP);
            U_LOAD:     w = mk(ACT_NOP,        C_FULL,      U_LFULL);
            U_LOAD_WR:  w = mk(ACT_LOAD_WRITE, C_ALWAYS,    U_REPORT);
            U_LFULL:    w = mk(ACT_STAT_FULL,  C_ALWAYS,    U_REPORT);
            U_ERASE:    w = mk(ACT_ERASE,      C_ALWAYS,    U_REPORT);
            U_STOPPED:  w = mk(ACT_COPY_STATE, C_ALWAYS,    U_REPORT);
            U_HALT:     w = mk(ACT_SET_HALT,   C_ALWAYS,    U_REPORT);
            U_PTR:      w = mk(ACT_SET_PTR,    C_ALWAYS,    U_REPORT);
            U_BRK:      w = mk(ACT_SET_BRK,    C_ALWAYS,    U_REPORT);
            U_WAIT:     w = mk(ACT_SET_WAIT,   C_ALWAYS,    U_REPORT);
            U_FINISH:   w = mk(ACT_FINISH,     C_ALWAYS,    U_REPORT);
            U_PLUS:     w = mk(ACT_INC_CELL,   C_ALWAYS,    U_FINISH);
            U_MINUS:    w = mk(ACT_DEC_CELL,   C_ALWAYS,    U_FINISH);
            U_RIGHT:    w = mk(ACT_NOP,        C_DP_LAST,   U_PTR);
            U_RIGHT_GO: w = mk(ACT_DP_INC,     C_ALWAYS,    U_FINISH);
            U_LEFT:     w = mk(ACT_NOP,        C_DP_ZERO,   U_PTR);
            U_LEFT_GO:  w = mk(ACT_DP_DEC,     C_ALWAYS,    U_FINISH);
            U_DOT:      w = mk(ACT_EMIT,       C_ALWAYS,    U_FINISH);
            U_COMMA:    w = mk(ACT_NOP,        C_NO_INPUT,  U_WAIT);
            U_COMMA_GO: w = mk(ACT_STORE_IN,   C_ALWAYS,    U_FINISH);
            U_OPEN:     w = mk(ACT_NOP,        C_CELL_NZ,   U_SKIP);
            U_FWD_INIT: w = mk(ACT_FWD_INIT,   C_NEVER,     U_IDLE);
            U_FWD_RD:   w = mk(ACT_FWD_READ,   C_IDX_END,   U_BRK);
            U_FWD_STEP: w = mk(ACT_FWD_STEP,   C_NO_MFWD,   U_FWD_RD);
            U_FWD_DONE: w = mk(ACT_NOP,        C_ALWAYS,    U_FINISH);
            U_CLOSE:    w = mk(ACT_NOP,        C_CELL_ZERO, U_SKIP);
            U_BWD_INIT: w = mk(ACT_BWD_INIT,   C_NEVER,     U_IDLE);
            U_BWD_RD:   w = mk(ACT_BWD_READ,   C_IDX_ZERO,  U_BRK);
            U_BWD_STEP: w = mk(ACT_BWD_STEP,   C_NO_MBWD,   U_BWD_RD);
            U_BWD_DONE: w = mk(ACT_NOP,        C_ALWAYS,    U_FINISH);
            U_SKIP:     w = mk(ACT_PC_INC,     C_ALWAYS,    U_FINISH);
            default:    w = mk(ACT_NOP,        C_ALWAYS,    U_IDLE);
        endcase
        return w;
    endfunction

    // Entry point of the routine for one program character
    function automatic t_upc op_entry(input logic [7:0] op);
        t_upc e;
        case (op)
            CH_PLUS:  e = U_PLUS;
            CH_MINUS: e = U_MINUS;
            CH_RIGHT: e = U_RIGHT;
            CH_LEFT:  e = U_LEFT;
            CH_DOT:   e = U_DOT;
            CH_COMMA: e = U_COMMA;
            CH_OPEN:  e = U_OPEN;
            CH_CLOSE: e = U_CLOSE;
            default:  e = U_SKIP;
        endcase
        return e;
    endfunction

endpackage

### src/brainfuck_processor.sv
// Top level of the brainfuck processor: sequencer plus datapath.
//
//  Channel  | Handshake            | Words carried
//  ---------+----------------------+-------------------------------------------------
//  command  | start / busy         | i_action, i_program_byte, i_input_byte,
//           |                      | i_input_valid
//  result   | o_strobe (one cycle) | o_out_valid, o_out_byte, o_status
//
// A command word is taken at an edge with start high and busy low; exactly one
// result word follows, shown for the single cycle o_strobe is high.
// The work per word is set by its microcode path: a plain step passes through
// decode, a registered program fetch and the tape read-modify-write, and a
// taken bracket jump adds a scan of the program one byte at a time.
// Restart walks the tape clearing one cell a cycle.
// Reset (synchronous, active low) runs the same clearing pass; busy stays high
// until it ends and no result is produced.
// The receiver cannot stall: o_strobe is never held off, and busy only
// reflects the sequencer being away from its idle step.
module brainfuck_processor import bfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_program_byte,
    input  logic [7:0] i_input_byte,
    input  logic       i_input_valid,
    output logic       o_strobe,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status
);

    t_act   act;
    t_flags flags;

    // Sequencer: walks the control store, branches on datapath flags
    bfp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_act   (act),
        .o_busy  (busy)
    );

    // Datapath: memories, pointers and result registers
    bfp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_act          (act),
        .i_action       (i_action),
        .i_program_byte (i_program_byte),
        .i_input_byte   (i_input_byte),
        .i_input_valid  (i_input_valid),
        .o_flags        (flags),
        .o_strobe       (o_strobe),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status)
    );

endmodule

### src/bfp_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
module bfp_useq import bfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_flags i_flags,
    output t_act   o_act,
    output logic   o_busy
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w;
    logic   take;

    assign w      = ucode(r_upc);
    assign o_act  = w.act;
    assign o_busy = (r_upc != U_IDLE);

    always_comb begin
        take = 1'b0;
        case (w.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_START:  take = !i_start;
            C_RESTART:   take = i_flags.is_restart;
            C_LOAD:      take = i_flags.is_load;
            C_ERASE:     take = i_flags.is_erase;
            C_STOPPED:   take = i_flags.stopped;
            C_PC_END:    take = i_flags.pc_end;
            C_DISPATCH:  take = 1'b1;
            C_FULL:      take = i_flags.full;
            C_DP_LAST:   take = i_flags.dp_last;
            C_DP_ZERO:   take = i_flags.dp_zero;
            C_NO_INPUT:  take = i_flags.no_input;
            C_CELL_NZ:   take = !i_flags.cell_zero;
            C_CELL_ZERO: take = i_flags.cell_zero;
            C_IDX_END:   take = i_flags.idx_end;
            C_IDX_ZERO:  take = i_flags.idx_zero;
            C_NO_MFWD:   take = !i_flags.match_fwd;
            C_NO_MBWD:   take = !i_flags.match_bwd;
            C_CLR_MORE:  take = i_flags.clr_more;
            C_BOOT:      take = i_flags.boot;
            default:     take = 1'b0;
        endcase

        if (w.cond == C_DISPATCH) begin
            n_upc = op_entry(i_flags.op);
        end else if (take) begin
            n_upc = w.tgt;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLR_INIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

### src/bfp_datapath.sv
// Datapath: program and tape memories, pointers, scan counters and result registers.
module bfp_datapath import bfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_act       i_act,
    input  logic [1:0] i_action,
    input  logic [7:0] i_program_byte,
    input  logic [7:0] i_input_byte,
    input  logic       i_input_valid,
    output t_flags     o_flags,
    output logic       o_strobe,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status
);

    logic [7:0] r_prog_mem [PROG_DEPTH];
    logic [7:0] r_tape_mem [TAPE_DEPTH];

    logic [1:0]         r_action;
    logic [7:0]         r_pbyte;
    logic [7:0]         r_ibyte;
    logic               r_ivalid;
    logic [LEN_W-1:0]   r_plen;
    logic [LEN_W-1:0]   r_pc;
    logic [TAPE_AW-1:0] r_dp;
    logic [2:0]         r_run;
    logic [2:0]         r_stat;
    logic               r_emit;
    logic [7:0]         r_ebyte;
    logic [LEN_W-1:0]   r_idx;
    logic [LEN_W-1:0]   r_depth;
    logic [TAPE_AW-1:0] r_caddr;
    logic               r_boot;
    logic               r_strobe;
    logic [7:0]         r_prog_q;
    logic [7:0]         r_tape_q;

    logic [LEN_W-1:0]   idx_m1;
    logic               prog_re;
    logic [PROG_AW-1:0] prog_raddr;
    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [7:0]         tape_wdata;
    logic               match_fwd;
    logic               match_bwd;
    logic               pc_end;

    assign idx_m1    = r_idx - 1'b1;
    assign match_fwd = (r_prog_q == CH_CLOSE) && (r_depth == '0);
    assign match_bwd = (r_prog_q == CH_OPEN) && (r_depth == '0);
    assign pc_end    = (r_pc >= r_plen);

    always_comb begin
        o_flags.is_restart = (r_action == A_RESTART);
        o_flags.is_load    = (r_action == A_LOAD);
        o_flags.is_erase   = (r_action == A_ERASE);
        o_flags.stopped    = (r_run != ST_RUN) && (r_run != ST_WAIT);
        o_flags.pc_end     = pc_end;
        o_flags.full       = (r_plen == PROG_FULL);
        o_flags.dp_last    = (r_dp == TAPE_LAST);
        o_flags.dp_zero    = (r_dp == '0);
        o_flags.no_input   = !r_ivalid;
        o_flags.cell_zero  = (r_tape_q == 8'd0);
        o_flags.idx_end    = (r_idx >= r_plen);
        o_flags.idx_zero   = (r_idx == '0);
        o_flags.match_fwd  = match_fwd;
        o_flags.match_bwd  = match_bwd;
        o_flags.clr_more   = (r_caddr != TAPE_LAST);
        o_flags.boot       = r_boot;
        o_flags.op         = r_prog_q;
    end

    // Memory port control
    always_comb begin
        prog_re    = 1'b0;
        prog_raddr = r_pc[PROG_AW-1:0];
        tape_we    = 1'b0;
        tape_waddr = r_dp;
        tape_wdata = r_ibyte;
        case (i_act)
            ACT_READ_OP:  prog_re = 1'b1;
            ACT_FWD_READ: begin
                prog_re    = 1'b1;
                prog_raddr = r_idx[PROG_AW-1:0];
            end
            ACT_BWD_READ: begin
                prog_re    = 1'b1;
                prog_raddr = idx_m1[PROG_AW-1:0];
            end
            ACT_CLR_WRITE: begin
                tape_we    = 1'b1;
                tape_waddr = r_caddr;
                tape_wdata = 8'd0;
            end
            ACT_INC_CELL: begin
                tape_we    = 1'b1;
                tape_wdata = r_tape_q + 8'd1;
            end
            ACT_DEC_CELL: begin
                tape_we    = 1'b1;
                tape_wdata = r_tape_q - 8'd1;
            end
            ACT_STORE_IN: tape_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_act == ACT_LOAD_WRITE) begin
            r_prog_mem[r_plen[PROG_AW-1:0]] <= r_pbyte;
        end
        if (prog_re) begin
            r_prog_q <= r_prog_mem[prog_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_waddr] <= tape_wdata;
        end
        if (i_act == ACT_READ_OP) begin
            r_tape_q <= r_tape_mem[r_dp];
        end
    end

    // Latched item
    always_ff @(posedge i_clk) begin
        if (i_act == ACT_LATCH) begin
            r_action <= i_action;
            r_pbyte  <= i_program_byte;
            r_ibyte  <= i_input_byte;
            r_ivalid <= i_input_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_pc     <= '0;
            r_dp     <= '0;
            r_run    <= ST_RUN;
            r_stat   <= ST_RUN;
            r_emit   <= 1'b0;
            r_ebyte  <= 8'd0;
            r_idx    <= '0;
            r_depth  <= '0;
            r_caddr  <= '0;
            r_boot   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_act == ACT_REPORT);
            case (i_act)
                ACT_LATCH: begin
                    r_emit  <= 1'b0;
                    r_ebyte <= 8'd0;
                end
                ACT_CLR_INIT: begin
                    r_caddr <= '0;
                    r_pc    <= '0;
                    r_dp    <= '0;
                    r_run   <= ST_RUN;
                    r_stat  <= ST_RUN;
                end
                ACT_CLR_WRITE:  r_caddr <= r_caddr + 1'b1;
                ACT_CLR_BOOT:   r_boot  <= 1'b0;
                ACT_LOAD_WRITE: begin
                    r_plen <= r_plen + 1'b1;
                    r_stat <= r_run;
                end
                ACT_STAT_FULL:  r_stat <= ST_FULL;
                ACT_ERASE: begin
                    r_plen <= '0;
                    r_pc   <= '0;
                    r_run  <= ST_RUN;
                    r_stat <= ST_RUN;
                end
                ACT_COPY_STATE: r_stat <= r_run;
                ACT_SET_HALT: begin
                    r_run  <= ST_HALT;
                    r_stat <= ST_HALT;
                end
                ACT_SET_PTR: begin
                    r_run  <= ST_PTR;
                    r_stat <= ST_PTR;
                end
                ACT_SET_BRK: begin
                    r_run  <= ST_BRACKET;
                    r_stat <= ST_BRACKET;
                end
                ACT_SET_WAIT: begin
                    r_run  <= ST_WAIT;
                    r_stat <= ST_WAIT;
                end
                ACT_FINISH: begin
                    r_run  <= pc_end ? ST_HALT : ST_RUN;
                    r_stat <= pc_end ? ST_HALT : ST_RUN;
                end
                ACT_INC_CELL, ACT_DEC_CELL, ACT_STORE_IN, ACT_PC_INC: begin
                    r_pc <= r_pc + 1'b1;
                end
                ACT_DP_INC: begin
                    r_dp <= r_dp + 1'b1;
                    r_pc <= r_pc + 1'b1;
                end
                ACT_DP_DEC: begin
                    r_dp <= r_dp - 1'b1;
                    r_pc <= r_pc + 1'b1;
                end
                ACT_EMIT: begin
                    r_emit  <= 1'b1;
                    r_ebyte <= r_tape_q;
                    r_pc    <= r_pc + 1'b1;
                end
                ACT_FWD_INIT: begin
                    r_idx   <= r_pc + 1'b1;
                    r_depth <= '0;
                end
                ACT_FWD_STEP: begin
                    if (match_fwd) begin
                        r_pc <= r_idx + 1'b1;
                    end else begin
                        if (r_prog_q == CH_OPEN) begin
                            r_depth <= r_depth + 1'b1;
                        end else if (r_prog_q == CH_CLOSE) begin
                            r_depth <= r_depth - 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ACT_BWD_INIT: begin
                    r_idx   <= r_pc;
                    r_depth <= '0;
                end
                ACT_BWD_READ: r_idx <= idx_m1;
                ACT_BWD_STEP: begin
                    if (match_bwd) begin
                        r_pc <= r_idx + 1'b1;
                    end else if (r_prog_q == CH_CLOSE) begin
                        r_depth <= r_depth + 1'b1;
                    end else if (r_prog_q == CH_OPEN) begin
                        r_depth <= r_depth - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_valid = r_emit;
    assign o_out_byte  = r_ebyte;
    assign o_status    = r_stat;

endmodule

### src/bfp_checker.sv
// Port-level checker for the brainfuck processor, bound to the top level.
module bfp_checker import bfp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_out_valid,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_status
);

    // A taken command always occupies the engine
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command taken but engine not busy");

    // A result comes out only once the engine has finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe while busy");

    // Results never come out back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in a row");

    // No emitted byte means a zero byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out_valid |-> o_out_byte == 8'd0)
        else $error("byte without emit");

    // An emit only comes from a completed instruction
    a_emit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out_valid |-> o_status == ST_RUN || o_status == ST_HALT)
        else $error("emit with error status");

endmodule

bind brainfuck_processor bfp_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_out_valid (o_out_valid),
    .o_out_byte  (o_out_byte),
    .o_status    (o_status)
);

### dv/brainfuck_processor_tb.sv
// Self-checking testbench for brainfuck_processor: predicted result words versus DUT output.
`timescale 1ns / 1ps

module brainfuck_processor_tb import bfp_pkg::*;;

    localparam int unsigned CYCLE_LIMIT = 12_000_000;
    localparam int          RANDOM_WORDS = 500;
    localparam int          REPORT_MAX = 10;

    // One result word as the block reports it
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic [2:0] status;
    } t_bf_reply;

    // Shadow copy of the machine: executes each accepted command word and queues
    // the result word it must produce, then matches DUT results in order.
    class bf_result_ledger;
        logic [7:0]         program_mem [PROG_DEPTH];
        logic [7:0]         cells [TAPE_DEPTH];
        logic [LEN_W-1:0]   prog_len;
        logic [LEN_W-1:0]   pc;
        logic [TAPE_AW-1:0] ptr;
        logic [2:0]         run_state;
        t_bf_reply          due[$];
        int                 mismatch_count;
        int                 words_seen;

        function new();
            foreach (program_mem[i]) program_mem[i] = '0;
            foreach (cells[i]) cells[i] = '0;
            prog_len       = '0;
            pc             = '0;
            ptr            = '0;
            run_state      = ST_RUN;
            mismatch_count = 0;
            words_seen     = 0;
        endfunction

        // Position of the ']' closing the '[' at pos, by nesting depth; -1 if none
        function int scan_forward(int pos);
            int depth;
            depth = 0;
            for (int i = pos + 1; i < prog_len; i++) begin
                if (program_mem[i] == CH_OPEN) begin
                    depth++;
                end else if (program_mem[i] == CH_CLOSE) begin
                    if (depth == 0) return i;
                    depth--;
                end
            end
            return -1;
        endfunction

        // Position of the '[' opening the ']' at pos, by nesting depth; -1 if none
        function int scan_backward(int pos);
            int depth;
            depth = 0;
            for (int i = pos - 1; i >= 0; i--) begin
                if (program_mem[i] == CH_CLOSE) begin
                    depth++;
                end else if (program_mem[i] == CH_OPEN) begin
                    if (depth == 0) return i;
                    depth--;
                end
            end
            return -1;
        endfunction

        // Execute one instruction; a fault leaves pc, pointer and tape alone
        function t_bf_reply execute_op(logic [7:0] in_byte, logic in_ok);
            t_bf_reply        r;
            logic [7:0]       opc;
            logic [LEN_W-1:0] next_pc;
            logic [2:0]       fault;
            int               hit;
            r = '0;
            if (run_state != ST_RUN && run_state != ST_WAIT) begin
                r.status = run_state;
                return r;
            end
            if (pc >= prog_len) begin
                run_state = ST_HALT;
                r.status  = run_state;
                return r;
            end
            opc     = program_mem[pc[PROG_AW-1:0]];
            next_pc = pc + 1'b1;
            fault   = ST_RUN;
            case (opc)
                CH_PLUS:  cells[ptr] = cells[ptr] + 8'd1;
                CH_MINUS: cells[ptr] = cells[ptr] - 8'd1;
                CH_RIGHT: begin
                    if (ptr == TAPE_LAST) fault = ST_PTR;
                    else ptr = ptr + 1'b1;
                end
                CH_LEFT: begin
                    if (ptr == '0) fault = ST_PTR;
                    else ptr = ptr - 1'b1;
                end
                CH_DOT: begin
                    r.out_valid = 1'b1;
                    r.out_byte  = cells[ptr];
                end
                CH_COMMA: begin
                    if (!in_ok) fault = ST_WAIT;
                    else cells[ptr] = in_byte;
                end
                CH_OPEN: begin
                    if (cells[ptr] == 8'd0) begin
                        hit = scan_forward(int'(pc));
                        if (hit < 0) fault = ST_BRACKET;
                        else next_pc = LEN_W'(hit + 1);
                    end
                end
                CH_CLOSE: begin
                    if (cells[ptr] != 8'd0) begin
                        hit = scan_backward(int'(pc));
                        if (hit < 0) fault = ST_BRACKET;
                        else next_pc = LEN_W'(hit + 1);
                    end
                end
                default: ;
            endcase
            if (fault != ST_RUN) begin
                run_state = fault;
            end else begin
                pc        = next_pc;
                run_state = (pc >= prog_len) ? ST_HALT : ST_RUN;
            end
            r.status = run_state;
            return r;
        endfunction

        // Note one accepted command word and queue its result word
        function void accept_word(logic [1:0] act, logic [7:0] pbyte, logic [7:0] ibyte,
                                  logic ivalid);
            t_bf_reply r;
            r = '0;
            case (act)
                A_RESTART: begin
                    foreach (cells[i]) cells[i] = '0;
                    pc        = '0;
                    ptr       = '0;
                    run_state = ST_RUN;
                    r.status  = run_state;
                end
                A_LOAD: begin
                    if (prog_len == PROG_FULL) begin
                        r.status = ST_FULL;
                    end else begin
                        program_mem[prog_len[PROG_AW-1:0]] = pbyte;
                        prog_len = prog_len + 1'b1;
                        r.status = run_state;
                    end
                end
                A_STEP: r = execute_op(ibyte, ivalid);
                A_ERASE: begin
                    prog_len  = '0;
                    pc        = '0;
                    run_state = ST_RUN;
                    r.status  = run_state;
                end
                default: ;
            endcase
            due.push_back(r);
        endfunction

        function void flag(string msg);
            if (mismatch_count < REPORT_MAX) $display("mismatch: %s", msg);
            mismatch_count++;
        endfunction

        // Compare one DUT result word with the oldest queued one
        function void check_word(logic ov, logic [7:0] ob, logic [2:0] st);
            t_bf_reply want;
            words_seen++;
            if (due.size() == 0) begin
                flag($sformatf("result %0d arrived with none pending: valid=%0b byte=%02h st=%0d",
                               words_seen, ov, ob, st));
                return;
            end
            want = due.pop_front();
            if (ov !== want.out_valid || ob !== want.out_byte || st !== want.status)
                flag($sformatf("result %0d: exp valid=%0b byte=%02h st=%0d, got valid=%0b byte=%02h st=%0d",
                               words_seen, want.out_valid, want.out_byte, want.status,
                               ov, ob, st));
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_action = A_STEP;
    logic [7:0] i_program_byte = 8'h00;
    logic [7:0] i_input_byte = 8'h00;
    logic       i_input_valid = 1'b0;
    logic       o_strobe;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;

    bf_result_ledger ledger;
    int              idle_pct = 0;
    int              words_sent = 0;
    int unsigned     cycle_count = 0;

    brainfuck_processor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_program_byte (i_program_byte),
        .i_input_byte   (i_input_byte),
        .i_input_valid  (i_input_valid),
        .o_strobe       (o_strobe),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Results cannot be held off: check every strobed word at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) ledger.check_word(o_out_valid, o_out_byte, o_status);
    end

    // Offer one command word, idling first at random, and hold it until taken.
    // Called right after a rising edge; start is assigned once per time step.
    task automatic send_word(input logic [1:0] act, input logic [7:0] pbyte,
                             input logic [7:0] ibyte, input logic ivalid);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_program_byte <= pbyte;
        i_input_byte   <= ibyte;
        i_input_valid  <= ivalid;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.accept_word(act, pbyte, ibyte, ivalid);
        words_sent++;
    endtask

    // Drop start and hold off until every pending result word has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.outstanding() != 0);
    endtask

    task automatic load_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_word(A_LOAD, bytes[i], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_step();
        send_word(A_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 3) != 0));
    endtask

    initial begin
        logic [7:0] prog[$];
        logic [7:0] ch;
        int         depth;
        int         roll;
        int         base;
        int         waited;
        bit         tidy;

        ledger = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset runs a tape-clearing pass; busy holds the first word off
        @(posedge i_clk);
        idle_pct = 18;

        // Directed: empty program halts, loads do not resume a halted run
        send_word(A_STEP, 8'h00, 8'h00, 1'b0);
        send_word(A_LOAD, CH_LEFT, 8'h00, 1'b0);
        send_word(A_STEP, 8'hFF, 8'hFF, 1'b1);
        send_word(A_ERASE, 8'h00, 8'h00, 1'b0);
        // Pointer error at the left end is sticky until restart
        send_word(A_LOAD, CH_LEFT, 8'h00, 1'b0);
        send_word(A_STEP, 8'h00, 8'h00, 1'b0);
        send_word(A_STEP, 8'h00, 8'h00, 1'b1);
        send_word(A_RESTART, 8'hFF, 8'hFF, 1'b1);
        send_word(A_ERASE, 8'h00, 8'h00, 1'b0);
        // No-op bytes, missing input, wrap both ways, nested forward skip,
        // then a backward jump that finds no matching bracket
        prog = '{8'h00, CH_COMMA, CH_DOT, CH_PLUS, CH_OPEN, CH_OPEN, CH_CLOSE, CH_CLOSE,
                 CH_MINUS, CH_DOT, 8'hFF, CH_CLOSE};
        load_bytes(prog);
        send_word(A_STEP, 8'h00, 8'h00, 1'b0);
        send_word(A_STEP, 8'h00, 8'h7E, 1'b0);
        send_word(A_STEP, 8'h00, 8'hFF, 1'b1);
        repeat (8) random_step();
        send_word(A_ERASE, 8'h00, 8'h00, 1'b0);
        drain_results();

        // Random: mostly erase, load a short program, run it; some raw noise
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            roll     = words_sent - base;
            idle_pct = (roll < RANDOM_WORDS / 3) ? 18 : (roll < 2 * RANDOM_WORDS / 3) ? 46 : 0;
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 3) == 0) drain_results();
                send_word(A_ERASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) < 25)
                    send_word(A_RESTART, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                // Mostly balanced brackets; now and then leave strays in
                tidy  = ($urandom_range(0, 9) != 0);
                depth = 0;
                prog.delete();
                repeat ($urandom_range(1, 20)) begin
                    roll = $urandom_range(0, 19);
                    if (roll < 3)       ch = CH_PLUS;
                    else if (roll < 5)  ch = CH_MINUS;
                    else if (roll < 7)  ch = CH_RIGHT;
                    else if (roll < 8)  ch = CH_LEFT;
                    else if (roll < 10) ch = CH_DOT;
                    else if (roll < 12) ch = CH_COMMA;
                    else if (roll < 14) ch = CH_OPEN;
                    else if (roll < 16) ch = CH_CLOSE;
                    else                ch = 8'($urandom_range(0, 255));
                    if (ch == CH_OPEN) begin
                        depth++;
                    end else if (ch == CH_CLOSE) begin
                        if (depth > 0) depth--;
                        else if (tidy) ch = CH_PLUS;
                    end
                    prog.push_back(ch);
                end
                if (tidy) repeat (depth) prog.push_back(CH_CLOSE);
                load_bytes(prog);
                repeat ($urandom_range(4, 40)) begin
                    if (ledger.run_state != ST_RUN && ledger.run_state != ST_WAIT) break;
                    // Occasionally append to the program while it runs
                    if ($urandom_range(0, 19) == 0)
                        send_word(A_LOAD, 8'($urandom_range(0, 255)), 8'h00, 1'b0);
                    else
                        random_step();
                end
            end
        end

        // Wait out the last words; a restart may still be clearing the tape
        drain_wait: begin
            start  <= 1'b0;
            waited = 0;
            while (ledger.outstanding() != 0 && waited < 2 * TAPE_DEPTH + 1000) begin
                @(posedge i_clk);
                waited++;
            end
        end
        repeat (32) @(posedge i_clk);
        if (ledger.outstanding() != 0)
            ledger.flag($sformatf("%0d result words never arrived", ledger.outstanding()));

        if (ledger.mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
